[hdl/oust_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and the control store of the OU step / running stats block.
// No dependencies; every other file in hdl/ imports this package.
package oust_pkg;

   // Field widths
   localparam int VAL_W   = 16;
   localparam int CNT_W   = 32;
   localparam int MACC_W  = 32;
   localparam int SQ_W    = 48;
   localparam int VAR_W   = 20;
   localparam int WIDX_W  = 10;
   localparam int CSR_W   = 16;
   localparam int CSR_AW  = 2;
   localparam int PROD_W  = 34;
   localparam int ACC_W   = 64;
   localparam int MAG_W   = 32;

   // Ring slot counter
   localparam int RING_DEPTH = 1024;
   localparam int RING_AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam logic [RING_AW-1:0] RING_LAST_IDX = RING_AW'(RING_DEPTH - 1);

   // Shared restoring divider
   localparam int DIV_W     = 36;
   localparam int DIVR_W    = 32;
   localparam int DIV_CNT_W = $clog2(DIV_W + 1);

   // Variance saturation point
   localparam logic [VAR_W-1:0] VAR_MAX = '1;

   // Register indexes
   localparam logic [CSR_AW-1:0] REG_LONG_RUN_MEAN = 2'd0;
   localparam logic [CSR_AW-1:0] REG_DECAY_FACTOR  = 2'd1;
   localparam logic [CSR_AW-1:0] REG_NOISE_GAIN    = 2'd2;

   // Microcode fields
   typedef enum logic [2:0] {
      MUL_NONE,
      MUL_DECAY,
      MUL_GAIN,
      MUL_LL,
      MUL_LH,
      MUL_HL,
      MUL_HH
   } mul_sel_type;

   typedef enum logic [2:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_ADD0,
      ACC_ADD16,
      ACC_ADD32
   } acc_op_type;

   typedef enum logic [3:0] {
      ALU_NOP,
      ALU_NEW_VALUE,
      ALU_DIFF_MEAN,
      ALU_DIV_MEAN,
      ALU_MEAN_UPD,
      ALU_DIFF_VAR,
      ALU_SQ_UPD,
      ALU_VAR_ZERO,
      ALU_DIV_VAR,
      ALU_VAR_SAT
   } alu_op_type;

   typedef enum logic [1:0] {
      COND_NEXT,
      COND_BUSY,
      COND_CNT_LT2,
      COND_DONE
   } cond_type;

   localparam int UPC_W = 5;

   typedef struct packed {
      mul_sel_type            mul_sel;
      acc_op_type             acc_op;
      alu_op_type             alu_op;
      cond_type               cond;
      logic [UPC_W-1:0]       target;
   } ucode_word_type;

   localparam ucode_word_type UCODE_NOP = '{
      mul_sel: MUL_NONE, acc_op: ACC_HOLD, alu_op: ALU_NOP,
      cond: COND_NEXT, target: '0};

   // Jump targets
   localparam logic [UPC_W-1:0] UA_WAIT_MEAN = UPC_W'(6);
   localparam logic [UPC_W-1:0] UA_WAIT_VAR  = UPC_W'(17);
   localparam logic [UPC_W-1:0] UA_FINISH    = UPC_W'(19);

   // Status from the datapath to the sequencer
   typedef struct packed {
      logic div_busy;
      logic cnt_lt2;
   } dp_status_type;

   // Configuration registers
   typedef struct packed {
      logic [CSR_W-1:0] mean;
      logic [CSR_W-1:0] decay;
      logic [CSR_W-1:0] gain;
   } cfg_type;

   // One result beat
   typedef struct packed {
      logic [VAL_W-1:0]  value;
      logic [VAL_W-1:0]  mean;
      logic [VAR_W-1:0]  variance;
      logic [CNT_W-1:0]  count;
      logic [WIDX_W-1:0] index;
   } result_type;

   // Control store: OU step, mean division, M2 product, variance division
   function automatic ucode_word_type ucode_rom(input logic [UPC_W-1:0] addr);
      ucode_word_type w;
      w = UCODE_NOP;
      unique case (addr)
         UPC_W'(0):  w.mul_sel = MUL_DECAY;
         UPC_W'(1):  begin
            w.mul_sel = MUL_GAIN;
            w.acc_op  = ACC_LOAD;
         end
         UPC_W'(2):  w.acc_op = ACC_ADD0;
         UPC_W'(3):  w.alu_op = ALU_NEW_VALUE;
         UPC_W'(4):  w.alu_op = ALU_DIFF_MEAN;
         UPC_W'(5):  w.alu_op = ALU_DIV_MEAN;
         UPC_W'(6):  begin
            w.cond   = COND_BUSY;
            w.target = UA_WAIT_MEAN;
         end
         UPC_W'(7):  w.alu_op = ALU_MEAN_UPD;
         UPC_W'(8):  w.alu_op = ALU_DIFF_VAR;
         UPC_W'(9):  w.mul_sel = MUL_LL;
         UPC_W'(10): begin
            w.mul_sel = MUL_LH;
            w.acc_op  = ACC_LOAD;
         end
         UPC_W'(11): begin
            w.mul_sel = MUL_HL;
            w.acc_op  = ACC_ADD16;
         end
         UPC_W'(12): begin
            w.mul_sel = MUL_HH;
            w.acc_op  = ACC_ADD16;
         end
         UPC_W'(13): w.acc_op = ACC_ADD32;
         UPC_W'(14): w.alu_op = ALU_SQ_UPD;
         UPC_W'(15): begin
            w.alu_op = ALU_VAR_ZERO;
            w.cond   = COND_CNT_LT2;
            w.target = UA_FINISH;
         end
         UPC_W'(16): w.alu_op = ALU_DIV_VAR;
         UPC_W'(17): begin
            w.cond   = COND_BUSY;
            w.target = UA_WAIT_VAR;
         end
         UPC_W'(18): w.alu_op = ALU_VAR_SAT;
         UPC_W'(19): w.cond = COND_DONE;
         default:    w = UCODE_NOP;
      endcase
      return w;
   endfunction

endpackage

[hdl/oust_divider.sv]
`timescale 1ns / 1ps
// Shared unsigned restoring divider, one quotient bit per cycle.
// Depends on oust_pkg for its widths.
module oust_divider import oust_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIV_W-1:0]  dividend,
   input  logic [DIVR_W-1:0] divisor,
   output logic              busy,
   output logic [DIV_W-1:0]  quotient
);

   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [DIVR_W-1:0]    rem_ff, rem_in;
   logic [DIVR_W-1:0]    dvs_ff, dvs_in;
   logic [DIV_CNT_W-1:0] step_ff, step_in;
   logic                 busy_ff, busy_in;
   logic [DIVR_W:0]      shifted;
   logic [DIVR_W+1:0]    trial;
   logic                 take;

   always_comb begin
      shifted = {rem_ff, quo_ff[DIV_W-1]};
      trial   = {1'b0, shifted} - {2'b00, dvs_ff};
      take    = !trial[DIVR_W+1];
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         step_in = DIV_CNT_W'(DIV_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = take ? trial[DIVR_W-1:0] : shifted[DIVR_W-1:0];
         quo_in  = {quo_ff[DIV_W-2:0], take};
         step_in = step_ff - DIV_CNT_W'(1);
         busy_in = (step_ff != DIV_CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

[hdl/oust_datapath.sv]
`timescale 1ns / 1ps
// Datapath of the OU step block: state registers, one 17x17 multiplier, accumulator, ALU ops.
// Depends on oust_pkg and oust_divider; driven by the microcode word from oust_sequencer.
module oust_datapath import oust_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  cfg_type          cfg,
   input  logic             load_en,
   input  logic [VAL_W-1:0] noise,
   input  ucode_word_type   ctrl,
   output dp_status_type    status,
   output result_type       result
);

   // Architectural state
   logic [VAL_W-1:0]   cv_ff, cv_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [MACC_W-1:0]  macc_ff, macc_in;
   logic [SQ_W-1:0]    sq_ff, sq_in;
   logic [RING_AW-1:0] head_ff, head_in;

   // Working registers
   logic [VAL_W-1:0]   noise_ff;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic [MAG_W-1:0]   da_ff, da_in;
   logic [MAG_W-1:0]   db_ff, db_in;
   logic               dneg_ff, dneg_in;
   logic [VAR_W-1:0]   var_ff, var_in;
   logic [WIDX_W-1:0]  slot_ff, slot_in;

   logic signed [16:0]       mul_a, mul_b;
   logic signed [PROD_W-1:0] mul_p;
   logic [ACC_W-1:0]         prod_ext;
   logic [34:0]              rnd;
   logic signed [19:0]       nv_sum;
   logic [VAL_W-1:0]         nv_sat;
   logic [MACC_W:0]          diff, diff_neg;
   logic [MAG_W-1:0]         diff_mag;
   logic [MACC_W-1:0]        qmag, mean_step;
   logic [SQ_W:0]            sq_sum;
   logic                     div_start, div_busy;
   logic [DIV_W-1:0]         div_dividend, div_quo;
   logic [DIVR_W-1:0]        div_divisor;

   oust_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .quotient (div_quo)
   );

   // Multiplier operand select
   always_comb begin
      unique case (ctrl.mul_sel)
         MUL_DECAY: begin
            mul_a = $signed({cv_ff[VAL_W-1], cv_ff}) - $signed({cfg.mean[CSR_W-1], cfg.mean});
            mul_b = $signed({1'b0, cfg.decay});
         end
         MUL_GAIN: begin
            mul_a = $signed({1'b0, cfg.gain});
            mul_b = $signed({noise_ff[VAL_W-1], noise_ff});
         end
         MUL_LL: begin
            mul_a = $signed({1'b0, da_ff[15:0]});
            mul_b = $signed({1'b0, db_ff[15:0]});
         end
         MUL_LH: begin
            mul_a = $signed({1'b0, da_ff[15:0]});
            mul_b = $signed({1'b0, db_ff[31:16]});
         end
         MUL_HL: begin
            mul_a = $signed({1'b0, da_ff[31:16]});
            mul_b = $signed({1'b0, db_ff[15:0]});
         end
         MUL_HH: begin
            mul_a = $signed({1'b0, da_ff[31:16]});
            mul_b = $signed({1'b0, db_ff[31:16]});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      mul_p = mul_a * mul_b;
   end

   always_comb begin
      prod_in  = (ctrl.mul_sel != MUL_NONE) ? mul_p : prod_ff;
      prod_ext = {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};

      unique case (ctrl.acc_op)
         ACC_LOAD:  acc_in = prod_ext;
         ACC_ADD0:  acc_in = acc_ff + prod_ext;
         ACC_ADD16: acc_in = acc_ff + {prod_ext[ACC_W-17:0], 16'h0000};
         ACC_ADD32: acc_in = acc_ff + {prod_ext[ACC_W-33:0], 32'h0000_0000};
         default:   acc_in = acc_ff;
      endcase

      // Round half up, floor shift, add the mean level, saturate
      rnd    = {acc_ff[PROD_W-1], acc_ff[PROD_W-1:0]} + 35'd32768;
      nv_sum = $signed({{4{cfg.mean[CSR_W-1]}}, cfg.mean}) + $signed({rnd[34], rnd[34:16]});
      if (nv_sum > 20'sd32767) begin
         nv_sat = 16'h7FFF;
      end else if (nv_sum < -20'sd32768) begin
         nv_sat = 16'h8000;
      end else begin
         nv_sat = nv_sum[VAL_W-1:0];
      end

      // x - mean_acc with x = value << 16; magnitude stays below 2^32
      diff     = {cv_ff[VAL_W-1], cv_ff, 16'h0000} - {macc_ff[MACC_W-1], macc_ff};
      diff_neg = -diff;
      diff_mag = diff[MACC_W] ? diff_neg[MAG_W-1:0] : diff[MAG_W-1:0];

      // Truncating division: apply the sign of d to floor(|d| / n)
      qmag      = div_quo[MACC_W-1:0];
      mean_step = dneg_ff ? (~qmag + MACC_W'(1)) : qmag;

      sq_sum = {1'b0, sq_ff} + {{(SQ_W-31){1'b0}}, acc_ff[ACC_W-1:32]};

      div_start    = (ctrl.alu_op == ALU_DIV_MEAN) || (ctrl.alu_op == ALU_DIV_VAR);
      div_dividend = (ctrl.alu_op == ALU_DIV_MEAN) ? {{(DIV_W-MAG_W){1'b0}}, da_ff}
                                                   : sq_ff[SQ_W-1:12];
      div_divisor  = (ctrl.alu_op == ALU_DIV_MEAN) ? cnt_ff : cnt_ff - CNT_W'(1);

      cv_in   = cv_ff;
      cnt_in  = cnt_ff;
      macc_in = macc_ff;
      sq_in   = sq_ff;
      head_in = head_ff;
      da_in   = da_ff;
      db_in   = db_ff;
      dneg_in = dneg_ff;
      var_in  = var_ff;
      slot_in = slot_ff;

      unique case (ctrl.alu_op)
         ALU_NEW_VALUE: begin
            cv_in   = nv_sat;
            cnt_in  = (cnt_ff == '1) ? cnt_ff : cnt_ff + CNT_W'(1);
            head_in = (head_ff == RING_LAST_IDX) ? '0 : head_ff + RING_AW'(1);
            slot_in = WIDX_W'(head_ff);
         end
         ALU_DIFF_MEAN: begin
            da_in   = diff_mag;
            dneg_in = diff[MACC_W];
         end
         ALU_MEAN_UPD: macc_in = macc_ff + mean_step;
         ALU_DIFF_VAR: db_in = diff_mag;
         ALU_SQ_UPD:   sq_in = sq_sum[SQ_W] ? '1 : sq_sum[SQ_W-1:0];
         ALU_VAR_ZERO: var_in = '0;
         ALU_VAR_SAT:  var_in = (div_quo[DIV_W-1:VAR_W] != '0) ? VAR_MAX : div_quo[VAR_W-1:0];
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cv_ff   <= '0;
         cnt_ff  <= '0;
         macc_ff <= '0;
         sq_ff   <= '0;
         head_ff <= '0;
      end else begin
         cv_ff   <= cv_in;
         cnt_ff  <= cnt_in;
         macc_ff <= macc_in;
         sq_ff   <= sq_in;
         head_ff <= head_in;
      end
      if (load_en) begin
         noise_ff <= noise;
      end
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      da_ff   <= da_in;
      db_ff   <= db_in;
      dneg_ff <= dneg_in;
      var_ff  <= var_in;
      slot_ff <= slot_in;
   end

   assign status.div_busy = div_busy;
   assign status.cnt_lt2  = (cnt_ff < CNT_W'(2));

   assign result.value    = cv_ff;
   assign result.mean     = macc_ff[MACC_W-1:16];
   assign result.variance = var_ff;
   assign result.count    = cnt_ff;
   assign result.index    = slot_ff;

endmodule

[hdl/oust_sequencer.sv]
`timescale 1ns / 1ps
// Microcode sequencer: step counter over the control store, conditional jumps, start and finish.
// Depends on oust_pkg for the control word layout and the control store function.
module oust_sequencer import oust_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic           drain_ok,
   input  dp_status_type  status,
   output ucode_word_type ctrl,
   output logic           idle,
   output logic           done
);

   logic [UPC_W-1:0] upc_ff, upc_in;
   logic             run_ff, run_in;
   ucode_word_type   word;

   assign word = ucode_rom(upc_ff);

   always_comb begin
      upc_in = upc_ff + UPC_W'(1);
      run_in = run_ff;
      done   = 1'b0;
      if (!run_ff) begin
         upc_in = '0;
         run_in = start;
      end else begin
         unique case (word.cond)
            COND_NEXT: ;
            COND_BUSY: begin
               if (status.div_busy) begin
                  upc_in = word.target;
               end
            end
            COND_CNT_LT2: begin
               if (status.cnt_lt2) begin
                  upc_in = word.target;
               end
            end
            COND_DONE: begin
               // hold here until the result register can take the beat
               upc_in = upc_ff;
               if (drain_ok) begin
                  done   = 1'b1;
                  run_in = 1'b0;
                  upc_in = '0;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= '0;
         run_ff <= 1'b0;
      end else begin
         upc_ff <= upc_in;
         run_ff <= run_in;
      end
   end

   assign ctrl = run_ff ? word : UCODE_NOP;
   assign idle = !run_ff;

endmodule

[hdl/ou_step_with_running_stats.sv]
`timescale 1ns / 1ps
// Top level: request/response channels, configuration registers, result register.
// Depends on oust_pkg, oust_sequencer and oust_datapath (which holds oust_divider).

// Each request beat carries one standard-normal noise sample (signed Q4.12). The block
// takes one Ornstein-Uhlenbeck step, value = mean + (value - mean)*decay + gain*noise,
// rounded half up and saturated to Q4.12, then updates the Welford count, running mean
// and M2 sum, and returns one response beat: the new value, the running mean, the
// sample variance (Q8.12, saturated, zero until two samples are in) and the count and
// ring slot of this step. Almost all of the work is the shared one-bit-per-cycle divider,
// run over its 36-bit dividend for the mean update and again for the variance, which is
// skipped while the count is below two. Work is sequenced by a 20-word control store. A
// finished result sits in the response register, so the next request is accepted while
// it waits; the sequencer only stalls at its final step if the previous result is still
// unread. Configuration registers (long_run_mean, decay_factor, noise_gain at indexes
// 0..2) are written through the csr port while the block is idle, a rule that binds the
// user and that the block does not enforce; other indexes are dropped.
module ou_step_with_running_stats import oust_pkg::*; (
   input  logic              clock,
   input  logic              reset,

   input  logic              req_valid,
   output logic              req_ready,
   input  logic signed [15:0] req_noise_sample,

   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic signed [15:0] rsp_process_value,
   output logic signed [15:0] rsp_running_mean,
   output logic [19:0]       rsp_sample_variance,
   output logic [31:0]       rsp_sample_count,
   output logic [9:0]        rsp_write_index,

   input  logic              csr_write_en,
   input  logic [1:0]        csr_index,
   input  logic [15:0]       csr_wdata
);

   // Configuration registers
   logic [CSR_W-1:0] mean_ff, mean_in;
   logic [CSR_W-1:0] decay_ff, decay_in;
   logic [CSR_W-1:0] gain_ff, gain_in;
   cfg_type          cfg;

   // Response register
   logic             rsp_valid_ff, rsp_valid_in;
   result_type       rsp_ff, rsp_in;

   logic             req_fire;
   logic             drain_ok;
   logic             seq_idle;
   logic             seq_done;
   ucode_word_type   ctrl;
   dp_status_type    status;
   result_type       result;

   // Accept a request beat only when the sequencer is free
   assign req_ready = seq_idle;
   assign req_fire  = req_valid && req_ready;

   // The result register frees up this cycle if it is empty or being read
   assign drain_ok = !rsp_valid_ff || rsp_ready;

   assign cfg.mean  = mean_ff;
   assign cfg.decay = decay_ff;
   assign cfg.gain  = gain_ff;

   oust_sequencer u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (req_fire),
      .drain_ok (drain_ok),
      .status   (status),
      .ctrl     (ctrl),
      .idle     (seq_idle),
      .done     (seq_done)
   );

   oust_datapath u_dp (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .load_en (req_fire),
      .noise   (req_noise_sample),
      .ctrl    (ctrl),
      .status  (status),
      .result  (result)
   );

   // Register writes; unknown indexes are ignored
   always_comb begin
      mean_in  = mean_ff;
      decay_in = decay_ff;
      gain_in  = gain_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            REG_LONG_RUN_MEAN: mean_in  = csr_wdata;
            REG_DECAY_FACTOR:  decay_in = csr_wdata;
            REG_NOISE_GAIN:    gain_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   // Load the result register at the end of a program, drop valid once the beat is taken
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (seq_done) begin
         rsp_in       = result;
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mean_ff      <= '0;
         decay_ff     <= 16'hFFFF;
         gain_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mean_ff      <= mean_in;
         decay_ff     <= decay_in;
         gain_ff      <= gain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_process_value   = $signed(rsp_ff.value);
   assign rsp_running_mean    = $signed(rsp_ff.mean);
   assign rsp_sample_variance = rsp_ff.variance;
   assign rsp_sample_count    = rsp_ff.count;
   assign rsp_write_index     = rsp_ff.index;

   // An accepted beat starts the program
   a_start_runs: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !seq_idle)
      else $error("sequencer did not start after request accept");

   // Never overwrite a result that has not been taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      seq_done |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten while full");

   // A result always counts at least this step
   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_sample_count != 32'd0))
      else $error("result beat with zero sample count");

   // Variance stays zero until two samples are in
   a_var_early_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_sample_count < 32'd2)) |-> (rsp_sample_variance == 20'd0))
      else $error("nonzero variance below two samples");

endmodule

[sim/ou_stats_checker.sv]
`timescale 1ns / 1ps
// Response checker for ou_step_with_running_stats: watches the req, rsp and csr ports,
// predicts every response beat and compares it. Depends on oust_pkg.
module ou_stats_checker import oust_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,

   input  logic                     req_valid,
   input  logic                     req_ready,
   input  logic signed [VAL_W-1:0]  req_noise_sample,

   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  logic signed [VAL_W-1:0]  rsp_process_value,
   input  logic signed [VAL_W-1:0]  rsp_running_mean,
   input  logic [VAR_W-1:0]         rsp_sample_variance,
   input  logic [CNT_W-1:0]         rsp_sample_count,
   input  logic [WIDX_W-1:0]        rsp_write_index,

   input  logic                     csr_write_en,
   input  logic [CSR_AW-1:0]        csr_index,
   input  logic [CSR_W-1:0]         csr_wdata,

   output int unsigned              error_count,
   output int unsigned              outstanding,
   output int unsigned              results_checked
);

   localparam logic [63:0] SQ_LIMIT = (64'd1 << SQ_W) - 64'd1;

   // Register copies
   logic signed [VAL_W-1:0] cfg_mean;
   logic [CSR_W-1:0]        cfg_decay;
   logic [CSR_W-1:0]        cfg_gain;

   // Process and Welford state
   logic signed [VAL_W-1:0]  cur_value;
   logic [CNT_W-1:0]         sample_cnt;
   logic signed [MACC_W-1:0] mean_acc;
   logic [SQ_W-1:0]          sq_sum;
   int unsigned              ring_head;

   result_type expected_q[$];

   // One OU step followed by the Welford update; returns the beat it should produce.
   // Count saturation is modeled, though a run of this length never gets there.
   function automatic result_type advance_process(input logic signed [VAL_W-1:0] noise);
      longint      v, mu, dk, gn, nz, drift, next_val, x, d, d2, macc_l, cnt_l;
      logic [63:0] mag_d, mag_d2, inc, sq64, var_q;
      result_type  r;
      v  = cur_value;
      mu = cfg_mean;
      dk = cfg_decay;
      gn = cfg_gain;
      nz = noise;
      drift    = (v - mu) * dk + gn * nz;
      next_val = mu + ((drift + 64'sd32768) >>> 16);
      if (next_val > 32767)
         next_val = 32767;
      if (next_val < -32768)
         next_val = -32768;
      cur_value = 16'(next_val);

      if (sample_cnt != '1)
         sample_cnt = sample_cnt + 1;
      cnt_l  = sample_cnt;
      x      = next_val * 65536;
      macc_l = mean_acc;
      d      = x - macc_l;
      mean_acc = 32'(macc_l + d / cnt_l);
      macc_l = mean_acc;
      d2     = x - macc_l;
      mag_d  = (d < 0) ? -d : d;
      mag_d2 = (d2 < 0) ? -d2 : d2;
      inc    = (mag_d * mag_d2) >> 32;
      sq64   = sq_sum;
      sq64   = (inc > SQ_LIMIT - sq64) ? SQ_LIMIT : sq64 + inc;
      sq_sum = sq64[SQ_W-1:0];

      if (sample_cnt < 2) begin
         var_q = '0;
      end else begin
         var_q = sq64 / ((64'(sample_cnt) - 64'd1) * 64'd4096);
         if (var_q > 64'(VAR_MAX))
            var_q = 64'(VAR_MAX);
      end

      r.value    = cur_value;
      r.mean     = 16'(mean_acc >>> 16);
      r.variance = var_q[VAR_W-1:0];
      r.count    = sample_cnt;
      r.index    = WIDX_W'(ring_head);
      ring_head  = (ring_head + 1 >= RING_DEPTH) ? 0 : ring_head + 1;
      return r;
   endfunction

   task automatic flag(input string what, input logic [63:0] want, input logic [63:0] got);
      error_count++;
      if (error_count <= 10)
         $display("%0t: beat %0d %s: expected %h, got %h",
                  $time, results_checked, what, want, got);
   endtask

   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (reset) begin
         cfg_mean   = '0;
         cfg_decay  = '1;
         cfg_gain   = '0;
         cur_value  = '0;
         sample_cnt = '0;
         mean_acc   = '0;
         sq_sum     = '0;
         ring_head  = 0;
         expected_q.delete();
         outstanding <= 0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               REG_LONG_RUN_MEAN: cfg_mean  = csr_wdata;
               REG_DECAY_FACTOR:  cfg_decay = csr_wdata;
               REG_NOISE_GAIN:    cfg_gain  = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            got.value    = rsp_process_value;
            got.mean     = rsp_running_mean;
            got.variance = rsp_sample_variance;
            got.count    = rsp_sample_count;
            got.index    = rsp_write_index;
            if (expected_q.size() == 0) begin
               flag("arrived with nothing expected, count", '0, got.count);
            end else begin
               want = expected_q.pop_front();
               if (got.value !== want.value)
                  flag("process_value", want.value, got.value);
               if (got.mean !== want.mean)
                  flag("running_mean", want.mean, got.mean);
               if (got.variance !== want.variance)
                  flag("sample_variance", want.variance, got.variance);
               if (got.count !== want.count)
                  flag("sample_count", want.count, got.count);
               if (got.index !== want.index)
                  flag("write_index", want.index, got.index);
            end
            results_checked++;
         end
         if (req_valid && req_ready)
            expected_q.push_back(advance_process(req_noise_sample));
         outstanding <= expected_q.size();
      end
   end

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// Top of the ou_step_with_running_stats bench: clock, reset, stimulus and verdict.
// Depends on oust_pkg, the block under test and ou_stats_checker.
module testbench;
   import oust_pkg::*;

   localparam int unsigned CYCLE_LIMIT     = 1_500_000;
   localparam int          RANDOM_PHASES   = 14;
   localparam int          ITEMS_PER_PHASE = 100;
   // Give the tail plenty of room after the last beat
   localparam int          DRAIN_CYCLES    = 300;
   localparam logic [CSR_AW-1:0] REG_UNMAPPED = 2'd3;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   logic signed [VAL_W-1:0] req_noise_sample;
   logic                    rsp_valid;
   logic                    rsp_ready;
   logic signed [VAL_W-1:0] rsp_process_value;
   logic signed [VAL_W-1:0] rsp_running_mean;
   logic [VAR_W-1:0]        rsp_sample_variance;
   logic [CNT_W-1:0]        rsp_sample_count;
   logic [WIDX_W-1:0]       rsp_write_index;
   logic                    csr_write_en;
   logic [CSR_AW-1:0]       csr_index;
   logic [CSR_W-1:0]        csr_wdata;

   int unsigned error_count;
   int unsigned outstanding;
   int unsigned results_checked;
   int unsigned cycle_count = 0;
   int unsigned samples_sent = 0;
   int unsigned settings_used = 0;

   ou_step_with_running_stats DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_noise_sample    (req_noise_sample),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_process_value   (rsp_process_value),
      .rsp_running_mean    (rsp_running_mean),
      .rsp_sample_variance (rsp_sample_variance),
      .rsp_sample_count    (rsp_sample_count),
      .rsp_write_index     (rsp_write_index),
      .csr_write_en        (csr_write_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   // Checker sits beside the block and sees exactly what crosses its ports
   ou_stats_checker scoreboard (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_noise_sample    (req_noise_sample),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_process_value   (rsp_process_value),
      .rsp_running_mean    (rsp_running_mean),
      .rsp_sample_variance (rsp_sample_variance),
      .rsp_sample_count    (rsp_sample_count),
      .rsp_write_index     (rsp_write_index),
      .csr_write_en        (csr_write_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .error_count         (error_count),
      .outstanding         (outstanding),
      .results_checked     (results_checked)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Watchdog: count every edge and bail out if the run hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout after %0d cycles, %0d beats still expected", cycle_count, outstanding);
      $display("FAIL ou_step_with_running_stats");
      $finish;
   end

   // Idle length: mostly none or a few cycles, now and then a long stretch
   function automatic int unsigned idle_len();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 50)
         return 0;
      if (pick < 85)
         return $urandom_range(1, 3);
      if (pick < 97)
         return $urandom_range(4, 12);
      return $urandom_range(30, 150);
   endfunction

   // Pick one end of a range or a random 16-bit word
   function automatic logic [15:0] edge_or_random(input logic [15:0] lo, input logic [15:0] hi);
      case ($urandom_range(0, 3))
         0:       return lo;
         1:       return hi;
         default: return 16'($urandom);
      endcase
   endfunction

   // Response side: alternate between free-running stretches and random stalls,
   // long enough that the finished beat sits unread while the next one computes.
   initial begin
      int unsigned stretch_left;
      int unsigned stall_left;
      bit          free_run;
      stretch_left = 0;
      stall_left   = 0;
      free_run     = 1'b0;
      rsp_ready   <= 1'b0;
      forever begin
         @(posedge clock);
         if (stretch_left == 0) begin
            free_run     = ($urandom_range(0, 3) == 0);
            stretch_left = $urandom_range(50, 400);
         end
         stretch_left--;
         if (free_run) begin
            rsp_ready <= 1'b1;
         end else if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 2) == 0)
               stall_left = idle_len() + 1;
         end
      end
   end

   // Send one noise beat. Drop valid first if a gap is wanted; otherwise keep it high
   // so consecutive beats go back to back. Returns in the step of the accepting edge.
   task automatic push_noise(input logic [VAL_W-1:0] noise, input int unsigned gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_noise_sample <= noise;
      do @(posedge clock); while (!req_ready);
      samples_sent++;
   endtask

   // Hold off the sender until every predicted beat has come back
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic write_reg(input logic [CSR_AW-1:0] idx, input logic [CSR_W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(posedge clock);
   endtask

   // Registers change only with the block drained
   task automatic configure(input logic [15:0] mean, input logic [15:0] decay,
                            input logic [15:0] gain);
      wait_idle();
      write_reg(REG_LONG_RUN_MEAN, mean);
      write_reg(REG_DECAY_FACTOR, decay);
      write_reg(REG_NOISE_GAIN, gain);
      csr_write_en <= 1'b0;
      settings_used++;
   endtask

   initial begin
      logic [VAL_W-1:0] noise;
      bit               quiet;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_noise_sample <= '0;
      csr_write_en     <= 1'b0;
      csr_index        <= '0;
      csr_wdata        <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: zero gain, so the value stays at the mean whatever the noise
      push_noise(16'h0000, idle_len());
      push_noise(16'h7FFF, idle_len());
      push_noise(16'h8000, idle_len());

      // Write to the unmapped index must be dropped; the checker keeps reset settings
      wait_idle();
      write_reg(REG_UNMAPPED, 16'hFFFF);
      csr_write_en <= 1'b0;

      // Zero decay, zero gain: value snaps to the top of the range
      configure(16'h7FFF, 16'h0000, 16'h0000);
      push_noise(16'h0000, idle_len());
      push_noise(16'h1234, idle_len());

      // Full decay and gain from the top: drive past positive saturation, then back
      configure(16'h7FFF, 16'hFFFF, 16'hFFFF);
      push_noise(16'h7FFF, idle_len());
      push_noise(16'h8000, idle_len());
      push_noise(16'h8000, idle_len());

      // Bottom mean with full gain: drive past negative saturation
      configure(16'h8000, 16'h0000, 16'hFFFF);
      push_noise(16'h8000, idle_len());
      push_noise(16'h7FFF, idle_len());

      // Smallest noise steps around zero, then the extremes
      configure(16'h0000, 16'hFFFF, 16'hFFFF);
      push_noise(16'hFFFF, idle_len());
      push_noise(16'h0001, idle_len());
      push_noise(16'h7FFF, idle_len());
      push_noise(16'h8000, idle_len());

      // Alternate between the rails to pump up M2 and the variance
      configure(16'h0000, 16'h0000, 16'hFFFF);
      repeat (2) begin
         push_noise(16'h7FFF, idle_len());
         push_noise(16'h8000, idle_len());
      end

      // Odd settings: mean just below zero, decay one half
      configure(16'hFFFF, 16'h8000, 16'd12345);
      push_noise(16'h5A5A, idle_len());
      push_noise(16'hA5A5, idle_len());

      // Random part: each phase drains, picks new settings (ends of the range often),
      // then streams noise. Every fourth phase runs the sender without gaps.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         quiet = (phase % 4 == 1);
         configure(edge_or_random(16'h8000, 16'h7FFF),
                   edge_or_random(16'h0000, 16'hFFFF),
                   edge_or_random(16'h0000, 16'hFFFF));
         for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
            if ($urandom_range(0, 15) == 0)
               noise = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            else
               noise = 16'($urandom);
            push_noise(noise, quiet ? 0 : idle_len());
         end
      end

      // Drain, then leave room for any stray beat to show up
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d noise samples under %0d register settings (rails, zero and full decay,",
               samples_sent, settings_used);
      $display("saturating gain, ring wrap); compared %0d response beats, %0d mismatches.",
               results_checked, error_count);
      if (error_count == 0)
         $display("PASS ou_step_with_running_stats");
      else
         $display("FAIL ou_step_with_running_stats");
      $finish;
   end

endmodule

[filelist.f]
hdl/oust_pkg.sv
hdl/oust_divider.sv
hdl/oust_datapath.sv
hdl/oust_sequencer.sv
hdl/ou_step_with_running_stats.sv
sim/ou_stats_checker.sv
sim/testbench.sv
